// ===== hdl/nrn_pkg.sv =====
// Shared types and constants for the newline run normalizer.
package nrn_pkg;

   localparam int CNT_W = 5;

   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   localparam logic [1:0] REG_MIN_RUN = 2'd0;
   localparam logic [1:0] REG_MAX_RUN = 2'd1;
   localparam logic [1:0] REG_STYLE   = 2'd2;

   localparam logic [CNT_W-1:0] MIN_RUN_RESET = 5'd0;
   localparam logic [CNT_W-1:0] MAX_RUN_RESET = 5'd16;

   typedef enum logic [1:0] {
      LE_CR   = 2'd0,
      LE_LF   = 2'd1,
      LE_CRLF = 2'd2,
      LE_LFCR = 2'd3
   } line_end_type;

   typedef struct packed {
      logic [CNT_W-1:0] min_run;
      logic [CNT_W-1:0] max_run;
      line_end_type     style;
   } cfg_type;

   // one queued job: emit cnt line ends, then the byte if has_byte
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic             has_byte;
      logic [7:0]       data;
   } cmd_type;

endpackage

// ===== hdl/nrn_front.sv =====
// Front end: accepts bytes, tracks the newline run and queues emit jobs.
module nrn_front #(
   parameter int MAX_RUN = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  nrn_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [7:0]       req_in_byte,
   input  logic             q_full,
   output logic             q_push,
   output nrn_pkg::cmd_type q_cmd
);

   localparam int RUN_W = $clog2(MAX_RUN + 1);
   localparam logic [RUN_W-1:0] RUN_SAT = RUN_W'(MAX_RUN);
   localparam logic [nrn_pkg::CNT_W-1:0] MAX_RUN_C = nrn_pkg::CNT_W'(MAX_RUN);

   logic [RUN_W-1:0] run_ff, run_in;
   logic             after_cr_ff, after_cr_in;

   logic                       fire;
   logic [RUN_W-1:0]           run_inc;
   logic [nrn_pkg::CNT_W-1:0]  run_w, raised, capped, emit_cnt;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;

   assign run_inc = (run_ff == RUN_SAT) ? run_ff : run_ff + RUN_W'(1);
   assign run_w   = nrn_pkg::CNT_W'(run_ff);
   assign raised  = (run_w < cfg.min_run) ? cfg.min_run : run_w;
   assign capped  = (raised > cfg.max_run) ? cfg.max_run : raised;
   assign emit_cnt = (run_ff == '0) ? '0 :
                     (capped > MAX_RUN_C) ? MAX_RUN_C : capped;

   always_comb begin
      run_in         = run_ff;
      after_cr_in    = after_cr_ff;
      q_push         = 1'b0;
      q_cmd.cnt      = emit_cnt;
      q_cmd.has_byte = 1'b0;
      q_cmd.data     = req_in_byte;
      if (fire) begin
         priority if (req_kind) begin
            q_push      = (emit_cnt != '0);
            run_in      = '0;
            after_cr_in = 1'b0;
         end else if (req_in_byte == nrn_pkg::BYTE_CR) begin
            run_in      = run_inc;
            after_cr_in = 1'b1;
         end else if (req_in_byte == nrn_pkg::BYTE_LF) begin
            if (!after_cr_ff) begin
               run_in = run_inc;
            end
            after_cr_in = 1'b0;
         end else begin
            q_push         = 1'b1;
            q_cmd.has_byte = 1'b1;
            run_in         = '0;
            after_cr_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= '0;
         after_cr_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         after_cr_ff <= after_cr_in;
      end
   end

endmodule

// ===== hdl/nrn_cmd_queue.sv =====
// Two-entry job queue between front and back.
module nrn_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nrn_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output nrn_pkg::cmd_type head
);

   nrn_pkg::cmd_type entries_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/nrn_back.sv =====
// Back end: plays out queued jobs as line-end and text beats.
module nrn_back (
   input  logic             clock,
   input  logic             reset,
   input  nrn_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  nrn_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);

   logic                      busy_ff;
   logic [nrn_pkg::CNT_W-1:0] left_ff;
   logic                      half_ff;
   logic                      has_byte_ff;
   logic [7:0]                data_ff;

   logic       fire, pair, pair_end, load;
   logic [7:0] le_char;

   assign pair     = (cfg.style == nrn_pkg::LE_CRLF) || (cfg.style == nrn_pkg::LE_LFCR);
   assign pair_end = !pair || half_ff;

   always_comb begin
      unique case (cfg.style)
         nrn_pkg::LE_CR:   le_char = nrn_pkg::BYTE_CR;
         nrn_pkg::LE_LF:   le_char = nrn_pkg::BYTE_LF;
         nrn_pkg::LE_CRLF: le_char = half_ff ? nrn_pkg::BYTE_LF : nrn_pkg::BYTE_CR;
         nrn_pkg::LE_LFCR: le_char = half_ff ? nrn_pkg::BYTE_CR : nrn_pkg::BYTE_LF;
         default:          le_char = nrn_pkg::BYTE_LF;
      endcase
   end

   assign rsp_valid    = busy_ff;
   assign rsp_out_byte = (left_ff != '0) ? le_char : data_ff;
   assign rsp_last     = (left_ff != '0) ?
                         (pair_end && left_ff == nrn_pkg::CNT_W'(1) && !has_byte_ff) : 1'b1;

   assign fire  = rsp_valid && rsp_ready;
   assign load  = q_valid && (!busy_ff || (fire && rsp_last));
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         half_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff     <= 1'b1;
            half_ff     <= 1'b0;
            left_ff     <= q_head.cnt;
            has_byte_ff <= q_head.has_byte;
            data_ff     <= q_head.data;
         end else if (fire) begin
            if (rsp_last) begin
               busy_ff <= 1'b0;
            end
            if (left_ff != '0) begin
               if (pair_end) begin
                  half_ff <= 1'b0;
                  left_ff <= left_ff - nrn_pkg::CNT_W'(1);
               end else begin
                  half_ff <= 1'b1;
               end
            end
         end
      end
   end

   a_job_not_empty: assert property (@(posedge clock) disable iff (reset)
      busy_ff && left_ff == '0 |-> has_byte_ff)
      else $error("active job has nothing left to emit");

   a_half_in_pair: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> busy_ff && pair && left_ff != '0)
      else $error("second half of line end outside a pair style");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_last && !q_valid |=> !busy_ff)
      else $error("back end stayed busy after final beat");

endmodule

// ===== hdl/newline_run_normalizer_unit.sv =====
// Newline run normalizer: top level with configuration registers.
// Throughput: one ordinary byte per cycle while the job queue has room; a newline
// run flush adds one beat per emitted line-end character (count or twice count,
// set by the back end player). CR and LF bytes themselves produce no beat.
// Reset (synchronous): run state, job queue and output cleared; min 0, max 16, LF.
module newline_run_normalizer_unit #(
   parameter int MAX_RUN = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata
);

   nrn_pkg::cfg_type cfg_ff;
   nrn_pkg::cmd_type push_cmd, head;
   logic             push, pop, full, not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_run <= nrn_pkg::MIN_RUN_RESET;
         cfg_ff.max_run <= nrn_pkg::MAX_RUN_RESET;
         cfg_ff.style   <= nrn_pkg::LE_LF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            nrn_pkg::REG_MIN_RUN: cfg_ff.min_run <= csr_wdata;
            nrn_pkg::REG_MAX_RUN: cfg_ff.max_run <= csr_wdata;
            nrn_pkg::REG_STYLE:   cfg_ff.style   <= nrn_pkg::line_end_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   nrn_front #(
      .MAX_RUN(MAX_RUN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_in_byte (req_in_byte),
      .q_full      (full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   nrn_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   nrn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (not_empty),
      .q_head       (head),
      .q_pop        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== dv/newline_run_normalizer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the newline run normalizer: predicts the emitted byte stream and compares beats.
module newline_run_normalizer_checker #(
   parameter int MAX_RUN = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata,
   output int         fail_count,
   output int         outstanding
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_beat_type;

   text_beat_type             text_q[$];
   logic [nrn_pkg::CNT_W-1:0] min_run_r;
   logic [nrn_pkg::CNT_W-1:0] max_run_r;
   nrn_pkg::line_end_type     style_r;
   logic [nrn_pkg::CNT_W-1:0] nl_run;
   logic                      after_cr;

   function automatic void push_text(input logic [7:0] b);
      text_beat_type e;
      e.data = b;
      e.last = 1'b0;
      text_q.push_back(e);
   endfunction

   function automatic void count_newline();
      if (nl_run < MAX_RUN) begin
         nl_run = nl_run + 1'b1;
      end
   endfunction

   // raise to min, cap at max, then at MAX_RUN
   function automatic void flush_run();
      int n;
      n = nl_run;
      if (n != 0) begin
         if (n < min_run_r) n = min_run_r;
         if (n > max_run_r) n = max_run_r;
         if (n > MAX_RUN) n = MAX_RUN;
         for (int i = 0; i < n; i++) begin
            case (style_r)
               nrn_pkg::LE_CR: push_text(nrn_pkg::BYTE_CR);
               nrn_pkg::LE_LF: push_text(nrn_pkg::BYTE_LF);
               nrn_pkg::LE_CRLF: begin
                  push_text(nrn_pkg::BYTE_CR);
                  push_text(nrn_pkg::BYTE_LF);
               end
               default: begin
                  push_text(nrn_pkg::BYTE_LF);
                  push_text(nrn_pkg::BYTE_CR);
               end
            endcase
         end
      end
      nl_run = '0;
   endfunction

   function automatic void normalize_beat(input logic is_eos, input logic [7:0] b);
      int base;
      base = text_q.size();
      if (is_eos) begin
         flush_run();
         after_cr = 1'b0;
      end else if (b == nrn_pkg::BYTE_CR) begin
         count_newline();
         after_cr = 1'b1;
      end else if (b == nrn_pkg::BYTE_LF) begin
         if (!after_cr) count_newline();
         after_cr = 1'b0;
      end else begin
         flush_run();
         push_text(b);
         after_cr = 1'b0;
      end
      if (text_q.size() > base) text_q[text_q.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin : beat_monitor
      text_beat_type want;
      if (reset) begin
         min_run_r = nrn_pkg::MIN_RUN_RESET;
         max_run_r = nrn_pkg::MAX_RUN_RESET;
         style_r   = nrn_pkg::LE_LF;
         nl_run    = '0;
         after_cr  = 1'b0;
         text_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               nrn_pkg::REG_MIN_RUN: min_run_r = csr_wdata;
               nrn_pkg::REG_MAX_RUN: max_run_r = csr_wdata;
               nrn_pkg::REG_STYLE:   style_r = nrn_pkg::line_end_type'(csr_wdata[1:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready) normalize_beat(req_kind, req_in_byte);
         if (rsp_valid && rsp_ready) begin
            if (text_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected beat, expected none, actual out_byte %02h last %b",
                        $time, rsp_out_byte, rsp_last);
            end else begin
               want = text_q.pop_front();
               if (rsp_out_byte !== want.data) begin
                  fail_count++;
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want.data, rsp_out_byte);
               end
               if (rsp_last !== want.last) begin
                  fail_count++;
                  $display("%0t: last mismatch, expected %b, actual %b",
                           $time, want.last, rsp_last);
               end
            end
         end
      end
      outstanding <= text_q.size();
   end

endmodule

// ===== dv/tb_newline_run_normalizer_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the newline run normalizer: clock, stimulus, config phases and verdict.
module tb_newline_run_normalizer_unit;

   localparam int         MAX_RUN     = 16;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         PHASE_ITEMS = 60;
   localparam int         HOLD_CYCLES = 300;
   localparam int         NUM_PHASES  = 8;
   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_EOS    = 1'b1;
   localparam logic [1:0] REG_UNUSED  = 2'd3;

   typedef struct {
      logic [4:0]            min_run;
      logic [4:0]            max_run;
      nrn_pkg::line_end_type style;
      int                    tx_idle;
      int                    rx_stall;
   } phase_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_kind    = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_ready   = 1'b0;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_index   = 2'd0;
   logic [4:0] csr_wdata   = 5'd0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   logic hold_req  = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   tx_idle_pct  = 0;
   int   rx_stall_pct = 0;
   int   cycle_count  = 0;
   int   items_sent   = 0;
   int   fail_count;
   int   outstanding;
   phase_type phases[NUM_PHASES];

   newline_run_normalizer_unit #(.MAX_RUN(MAX_RUN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   newline_run_normalizer_checker #(.MAX_RUN(MAX_RUN)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_newline_run_normalizer_unit failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == nrn_pkg::BYTE_CR || b == nrn_pkg::BYTE_LF);
      return b;
   endfunction

   // called at a clock edge; returns at the edge where the beat is taken
   task automatic send_beat(input logic kind, input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // CR, LF, CRLF, or CR CR LF (two newlines)
   task automatic send_newlines(input int len);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(3))
            0: send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
            1: send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
            2: begin
               send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
               send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
            end
            default: begin
               send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
               send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
               send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
            end
         endcase
      end
   endtask

   task automatic random_chunk();
      int sel;
      int len;
      sel = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 14) : $urandom_range(4, 1);
      if (sel < 45) begin
         send_beat(KIND_DATA, text_byte());
      end else if (sel < 85) begin
         send_newlines(len);
         send_beat(KIND_DATA, text_byte());
      end else if (sel < 93) begin
         if ($urandom_range(1)) send_newlines(len);
         send_beat(KIND_EOS, 8'($urandom_range(255)));
      end else begin
         send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
   endtask

   task automatic directed_items();
      send_beat(KIND_DATA, 8'h41);
      send_beat(KIND_DATA, 8'h00);
      send_beat(KIND_DATA, 8'hFF);
      send_beat(KIND_DATA, 8'h7F);
      send_beat(KIND_EOS, 8'h00);
      send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
      send_beat(KIND_DATA, 8'h62);
      send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
      send_beat(KIND_DATA, 8'h63);
      send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
      send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
      send_beat(KIND_DATA, 8'h64);
      send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
      send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
      send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
      send_beat(KIND_DATA, 8'h65);
      send_beat(KIND_DATA, nrn_pkg::BYTE_LF);
      send_beat(KIND_DATA, nrn_pkg::BYTE_CR);
      send_beat(KIND_EOS, 8'hFF);
   endtask

   task automatic apply_phase(input phase_type ph);
      drain();
      write_reg(nrn_pkg::REG_MIN_RUN, ph.min_run);
      write_reg(nrn_pkg::REG_MAX_RUN, ph.max_run);
      write_reg(nrn_pkg::REG_STYLE, {3'b000, ph.style});
      csr_wr_en    <= 1'b0;
      tx_idle_pct  <= ph.tx_idle;
      rx_stall_pct <= ph.rx_stall;
      @(posedge clock);
   endtask

   initial begin
      int start;
      phases[0] = '{5'd0,  5'd16, nrn_pkg::LE_LF,   0,  0};
      phases[1] = '{5'd2,  5'd5,  nrn_pkg::LE_CRLF, 88, 0};
      phases[2] = '{5'd16, 5'd16, nrn_pkg::LE_CR,   0,  88};
      phases[3] = '{5'd7,  5'd3,  nrn_pkg::LE_LFCR, 25, 25};
      phases[4] = '{5'd31, 5'd31, nrn_pkg::LE_CRLF, 0,  0};
      phases[5] = '{5'd0,  5'd0,  nrn_pkg::LE_LF,   88, 0};
      phases[6] = '{5'd1,  5'd31, nrn_pkg::LE_CR,   0,  88};
      phases[7] = '{5'($urandom_range(31)), 5'($urandom_range(31)),
                    nrn_pkg::line_end_type'($urandom_range(3)), 25, 25};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_phase(phases[p]);
         if (p == 0) begin
            write_reg(REG_UNUSED, 5'($urandom_range(31)));
            csr_wr_en <= 1'b0;
            @(posedge clock);
         end
         if (p == 2) hold_req <= ~hold_req;
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            random_chunk();
            if (p == 3 && items_sent - start >= PHASE_ITEMS / 2
                && items_sent - start < PHASE_ITEMS / 2 + 4) begin
               drain();
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_newline_run_normalizer_unit passed");
      end else begin
         $display("tb_newline_run_normalizer_unit failed");
      end
      $finish;
   end

endmodule
